>>> rtl/vdit_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdit_pkg
// shared types and constants of the vertex deduplication index table
// ---------------------------------------------------------------------------
package vdit_pkg;

   localparam int NUM_COMP  = 12;   // components in one vertex
   localparam int COMP_W    = 32;   // one signed q16.16 component
   localparam int VTX_W     = NUM_COMP * COMP_W;
   localparam int TOL_W     = 16;   // match tolerance register
   localparam int OUT_IDX_W = 8;    // index carried on the result channel

   typedef logic [NUM_COMP-1:0][COMP_W-1:0] vertex_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic                 active;  // a lookup is passing this cell
      logic                 found;   // an earlier cell matched or stored
      logic                 added;   // the vertex was appended
      logic [OUT_IDX_W-1:0] index;   // low bits of the resolved entry
   } token_type;

endpackage

>>> rtl/vdit_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vdit_cell
// one table entry with its tolerance compare and the token stage after it
// ---------------------------------------------------------------------------
module vdit_cell #(
   parameter int TABLE_DEPTH = 256,
   parameter int CELL_IDX    = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  vdit_pkg::vertex_type               vertex,
   input  logic [vdit_pkg::TOL_W-1:0]         tolerance,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]   entry_count,
   input  vdit_pkg::token_type                tok_prev,
   output vdit_pkg::token_type                tok_next
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IW    = vdit_pkg::OUT_IDX_W;
   localparam int DW    = vdit_pkg::COMP_W + 1;
   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);
   localparam logic [IW-1:0]    MY_IDX = IW'(CELL_IDX);

   vdit_pkg::vertex_type  entry_ff;
   vdit_pkg::token_type   tok_ff, tok_in;
   logic [vdit_pkg::NUM_COMP-1:0] close;
   logic live, hit, append;

   // per-component |stored - incoming| <= tolerance, exact in 33 bits
   always_comb begin
      logic [DW-1:0] diff;
      logic [DW-1:0] mag;
      for (int c = 0; c < vdit_pkg::NUM_COMP; c++) begin
         diff = {entry_ff[c][vdit_pkg::COMP_W-1], entry_ff[c]}
              - {vertex[c][vdit_pkg::COMP_W-1], vertex[c]};
         mag = diff[DW-1] ? (~diff + DW'(1)) : diff;
         close[c] = (mag <= DW'(tolerance));
      end
   end

   assign live   = tok_prev.active && !tok_prev.found;
   assign hit    = live && (MY_POS < entry_count) && (&close);
   assign append = live && (MY_POS == entry_count);

   always_comb begin
      tok_in = tok_prev;
      if (hit) begin
         tok_in.found = 1'b1;
         tok_in.index = MY_IDX;
      end else if (append) begin
         tok_in.found = 1'b1;
         tok_in.added = 1'b1;
         tok_in.index = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (append) begin
         entry_ff <= vertex;
      end
   end

   assign tok_next = tok_ff;

endmodule

>>> rtl/vertex_dedup_index_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vertex_dedup_index_table
// tolerance-based vertex deduplication over a row of table cells
// ---------------------------------------------------------------------------
// usage
//   req channel: one vertex per transaction, twelve signed q16.16 components
//   in req_tdata, req_tuser set on the first vertex of a material group,
//   which empties the table before the lookup
//   rsp channel: one transaction per vertex with the entry index in
//   rsp_tdata and the appended / overflow flags in rsp_tuser
//   csr_wr_en / csr_wr_data write the match tolerance, only while idle
// timing
//   a lookup token walks the row of cells, one cell per cycle; an accepted
//   vertex goes through the launch register, the token register of every
//   cell, the holding register and then the output register that drives
//   rsp_tvalid; one vertex is in the row at a time
//   the next vertex is accepted as soon as the previous result sits in the
//   output register, even while rsp_tready is low
// reset
//   the table is emptied and the tolerance returns to 66; cell contents are
//   not cleared, entries at or above the fill count are never compared
// stall
//   a finished result waits in a holding register until the output register
//   frees up; req_tready stays low meanwhile
// ---------------------------------------------------------------------------
module vertex_dedup_index_table #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   // vertex in: pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
   // col_r, col_g, col_b, col_a, tex_uv (64 bits)
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [vdit_pkg::VTX_W-1:0]          req_tdata,
   input  logic                                req_tuser,   // first_of_group
   // result out
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [vdit_pkg::OUT_IDX_W-1:0]      rsp_tdata,   // vertex_index
   output logic [1:0]                          rsp_tuser,   // table_overflow in bit 1, was_added in bit 0
   // tolerance register
   input  logic                                csr_wr_en,
   input  logic [vdit_pkg::TOL_W-1:0]          csr_wr_data
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IW    = vdit_pkg::OUT_IDX_W;
   localparam logic [vdit_pkg::TOL_W-1:0] TOL_RESET = vdit_pkg::TOL_W'(66);
   localparam logic [CNT_W-1:0]           CNT_FULL  = CNT_W'(TABLE_DEPTH);

   logic                          busy_ff, launch_ff, pend_ff, rsp_valid_ff;
   vdit_pkg::vertex_type          vtx_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [vdit_pkg::TOL_W-1:0]    tol_ff;
   vdit_pkg::token_type           pend_tok_ff;
   logic [IW-1:0]                 rsp_idx_ff;
   logic                          rsp_added_ff, rsp_ovf_ff;

   vdit_pkg::token_type           tok_chain [TABLE_DEPTH+1];
   vdit_pkg::token_type           tok_end;
   logic                          req_fire, out_load;

   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign tok_end    = tok_chain[TABLE_DEPTH];
   // the holding register moves on when the output register is free
   assign out_load   = pend_ff && (!rsp_valid_ff || rsp_tready);

   // token entering the first cell
   always_comb begin
      tok_chain[0]        = '0;
      tok_chain[0].active = launch_ff;
   end

   // row of table cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      vdit_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .CELL_IDX    (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .vertex      (vtx_ff),
         .tolerance   (tol_ff),
         .entry_count (count_ff),
         .tok_prev    (tok_chain[i]),
         .tok_next    (tok_chain[i+1])
      );
   end

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // control: busy flag, launch pulse, fill count, result handoff
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         launch_ff <= req_fire;
         if (req_fire) begin
            busy_ff <= 1'b1;
            if (req_tuser) begin
               count_ff <= '0;
            end
         end
         if (tok_end.active) begin
            pend_ff <= 1'b1;
            if (tok_end.added) begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end
         if (out_load) begin
            pend_ff      <= 1'b0;
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         vtx_ff <= req_tdata;
      end
      if (tok_end.active) begin
         pend_tok_ff <= tok_end;
      end
      if (out_load) begin
         // no cell resolved the lookup only when the table was full
         rsp_idx_ff   <= pend_tok_ff.found ? pend_tok_ff.index : '0;
         rsp_added_ff <= pend_tok_ff.added;
         rsp_ovf_ff   <= !pend_tok_ff.found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_idx_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_added_ff};

   // fill count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("fill count beyond table depth");

   // a lookup only leaves the row while an item is in flight
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      tok_end.active |-> busy_ff && !pend_ff)
      else $error("lookup finished with no item in flight");

   // appended and overflow never flagged together
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_added_ff && rsp_ovf_ff))
      else $error("appended and overflow both set");

   // overflow result carries index zero
   a_ovf_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (rsp_idx_ff == '0))
      else $error("overflow result with non-zero index");

   // a group start empties the table before the lookup launches
   a_group_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser) |=> (count_ff == '0) && launch_ff)
      else $error("group start did not empty the table");

endmodule

>>> test/tb_vertex_dedup_index_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_vertex_dedup_index_table
// self-checking stream testbench for the tolerance-based vertex dedup table
// ---------------------------------------------------------------------------
// vertices are queued by the stimulus process and driven on the req channel
// at the falling edge with random gaps; results are taken at the rising edge
// under random back-pressure and checked field by field against a local copy
// of the table that is looked up for every accepted vertex; the tolerance is
// rewritten between phases while the block is idle, from 0 to 65535, and one
// phase fills the table past its depth to exercise overflow
// ---------------------------------------------------------------------------
module tb_vertex_dedup_index_table;

   localparam int TABLE_DEPTH = 256;
   localparam int NUM_COMP    = vdit_pkg::NUM_COMP;
   localparam int COMP_W      = vdit_pkg::COMP_W;
   localparam int VTX_W       = vdit_pkg::VTX_W;
   localparam int TOL_W       = vdit_pkg::TOL_W;
   localparam int OUT_IDX_W   = vdit_pkg::OUT_IDX_W;

   typedef vdit_pkg::vertex_type vertex_type;

   // one queued vertex and the flag that starts a new material group
   typedef struct {
      vertex_type data;
      logic       first;
   } vertex_item_type;

   // expected result fields of one lookup
   typedef struct packed {
      logic [OUT_IDX_W-1:0] index;
      logic                 added;
      logic                 overflow;
   } dedup_result_type;

   // ------------------------------------------------------------------------
   // clock, reset and block ports, every driven input known from time zero
   // ------------------------------------------------------------------------
   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_tvalid  = 1'b0;
   logic                 req_tready;
   logic [VTX_W-1:0]     req_tdata   = '0;
   logic                 req_tuser   = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready  = 1'b0;
   logic [OUT_IDX_W-1:0] rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 csr_wr_en   = 1'b0;
   logic [TOL_W-1:0]     csr_wr_data = '0;

   always #2 clock = ~clock;

   vertex_dedup_index_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // pos_x .. col_a, tex_uv (v low, u high)
      .req_tuser   (req_tuser),   // first_of_group
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // vertex_index
      .rsp_tuser   (rsp_tuser),   // table_overflow in bit 1, was_added in bit 0
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ------------------------------------------------------------------------
   // local copy of the table, the tolerance and the queues
   // ------------------------------------------------------------------------
   vertex_type       table_copy [TABLE_DEPTH];
   int unsigned      fill_count    = 0;
   logic [TOL_W-1:0] tolerance_now = 16'd66;   // value after reset

   vertex_item_type  pending_vertices [$];
   dedup_result_type expected_results [$];
   vertex_type       group_vertices   [$];   // first vertices of the group, up to 64
   int               mismatch_count = 0;

   // handshake flags sampled at the rising edge, read at the falling edge
   logic             req_fire = 1'b0;
   logic             rsp_fire = 1'b0;

   // exact difference in 64 bits, so opposite ends of the range never wrap
   function automatic bit comp_close(logic [COMP_W-1:0] a,
                                     logic [COMP_W-1:0] b);
      longint diff;
      diff = longint'($signed(a)) - longint'($signed(b));
      if (diff < 0)
         diff = -diff;
      return diff <= longint'(tolerance_now);
   endfunction

   function automatic bit vertex_close(vertex_type a, vertex_type b);
      for (int k = 0; k < NUM_COMP; k++)
         if (!comp_close(a[k], b[k]))
            return 1'b0;
      return 1'b1;
   endfunction

   // lowest matching entry, else append, else overflow with index 0
   function automatic dedup_result_type lookup_vertex(vertex_type v, logic first);
      dedup_result_type res;
      int               hit;
      hit = -1;
      if (first)
         fill_count = 0;
      for (int i = 0; i < fill_count && hit < 0; i++)
         if (vertex_close(table_copy[i], v))
            hit = i;
      res = '0;
      if (hit >= 0) begin
         res.index = hit[OUT_IDX_W-1:0];
      end else if (fill_count < TABLE_DEPTH) begin
         table_copy[fill_count] = v;
         res.index = fill_count[OUT_IDX_W-1:0];
         res.added = 1'b1;
         fill_count++;
      end else begin
         res.overflow = 1'b1;
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic vertex_type uniform_vertex(logic [COMP_W-1:0] c);
      vertex_type v;
      for (int k = 0; k < NUM_COMP; k++)
         v[k] = c;
      return v;
   endfunction

   // mostly short gaps, a few long ones, none at all in calm stretches
   function automatic int draw_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 2);
      if (r < 97)
         return $urandom_range(3, 10);
      return $urandom_range(20, 60);
   endfunction

   // extremes, values around zero and plain random words
   function automatic logic [COMP_W-1:0] random_comp();
      case ($urandom_range(0, 9))
         0: begin
            return 32'h7fff_ffff;
         end
         1: begin
            return 32'h8000_0000;
         end
         2: begin
            return 32'h0000_0000;
         end
         3: begin
            return 32'hffff_ffff;
         end
         4, 5: begin
            return COMP_W'($urandom_range(0, 600) - 300);
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // fresh vertex, exact repeat or near copy of a vertex of this group;
   // a near copy misses by one step in a single component now and then
   function automatic vertex_type random_vertex(int tol, int fresh_pct);
      vertex_type v;
      vertex_type base;
      int         r;
      int         delta;
      int         miss_comp;
      r = $urandom_range(0, 99);
      if (group_vertices.size() == 0 || r < fresh_pct) begin
         for (int k = 0; k < NUM_COMP; k++)
            v[k] = random_comp();
      end else begin
         base = group_vertices[$urandom_range(0, group_vertices.size() - 1)];
         v = base;
         if (r % 3 != 0) begin
            miss_comp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_COMP - 1) : -1;
            for (int k = 0; k < NUM_COMP; k++) begin
               if (k == miss_comp)
                  delta = $urandom_range(0, 1) ? tol + 1 : -(tol + 1);
               else
                  delta = int'($urandom_range(0, 2 * tol)) - tol;
               v[k] = base[k] + COMP_W'(delta);
            end
         end
      end
      if (group_vertices.size() < 64)
         group_vertices.insert(group_vertices.size(), v);
      return v;
   endfunction

   task automatic push_vertex(vertex_type v, logic first);
      vertex_item_type item;
      item.data  = v;
      item.first = first;
      if (first)
         group_vertices.delete();
      pending_vertices.insert(pending_vertices.size(), item);
   endtask

   // wait until every queued vertex has been sent and answered
   task automatic settle_idle();
      while (!(pending_vertices.size() == 0 && !req_tvalid && expected_results.size() == 0))
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_tolerance(logic [TOL_W-1:0] value);
      settle_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_random_phase(int tol, int count, int first_pct, int fresh_pct);
      set_tolerance(TOL_W'(tol));
      for (int n = 0; n < count; n++)
         push_vertex(random_vertex(tol, fresh_pct), $urandom_range(0, 99) < first_pct);
   endtask

   // ------------------------------------------------------------------------
   // req driver: next item at the falling edge once the current one is gone
   // ------------------------------------------------------------------------
   int              req_gap  = 0;
   bit              req_calm = 1'b0;
   vertex_item_type req_item;

   always @(negedge clock) begin
      if ($urandom_range(0, 149) == 0)
         req_calm = ~req_calm;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_vertices.size() != 0) begin
            req_item = pending_vertices.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= req_item.data;
            req_tuser  <= req_item.first;
            req_gap = draw_gap(req_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // rsp back-pressure: stalls after a transaction and at random moments
   // ------------------------------------------------------------------------
   int rsp_hold = 0;
   bit rsp_calm = 1'b0;

   always @(negedge clock) begin
      if ($urandom_range(0, 149) == 0)
         rsp_calm = ~rsp_calm;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_fire || $urandom_range(0, 7) == 0)
            rsp_hold = draw_gap(rsp_calm);
      end
   end

   // ------------------------------------------------------------------------
   // monitor: predict on each accepted vertex, check each accepted result
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      dedup_result_type exp_res;
      req_fire <= !reset && req_tvalid && req_tready;
      rsp_fire <= !reset && rsp_tvalid && rsp_tready;
      if (!reset) begin
         // tolerance takes effect at the edge of the write
         if (csr_wr_en)
            tolerance_now = csr_wr_data;
         if (req_tvalid && req_tready)
            expected_results.insert(expected_results.size(),
                                    lookup_vertex(vertex_type'(req_tdata), req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result index %0d added %0b overflow %0b",
                        $time, rsp_tdata, rsp_tuser[0], rsp_tuser[1]);
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_tdata !== exp_res.index) begin
                  mismatch_count++;
                  $display("%0t: vertex_index expected %0d actual %0d",
                           $time, exp_res.index, rsp_tdata);
               end
               if (rsp_tuser[0] !== exp_res.added) begin
                  mismatch_count++;
                  $display("%0t: was_added expected %0b actual %0b",
                           $time, exp_res.added, rsp_tuser[0]);
               end
               if (rsp_tuser[1] !== exp_res.overflow) begin
                  mismatch_count++;
                  $display("%0t: table_overflow expected %0b actual %0b",
                           $time, exp_res.overflow, rsp_tuser[1]);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus sequence
   // ------------------------------------------------------------------------
   initial begin
      vertex_type v;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // tolerance after reset: boundary of the match window
      push_vertex(uniform_vertex(32'd0), 1'b1);
      push_vertex(uniform_vertex(32'd0), 1'b0);
      push_vertex(uniform_vertex(32'd66), 1'b0);
      v = uniform_vertex(32'd0);
      v[0] = 32'd67;
      push_vertex(v, 1'b0);
      push_vertex(uniform_vertex(-32'sd66), 1'b0);
      // opposite ends of the range stay apart whatever the tolerance
      push_vertex(uniform_vertex(32'h7fff_ffff), 1'b0);
      push_vertex(uniform_vertex(32'h8000_0000), 1'b0);
      push_vertex(uniform_vertex(32'h7fff_ffff - 32'd66), 1'b0);
      push_vertex(uniform_vertex(32'h8000_0000 + 32'd66), 1'b0);
      // texture u and v differ alone
      v = uniform_vertex(32'd0);
      v[11] = 32'd67;
      push_vertex(v, 1'b0);
      v = uniform_vertex(32'd0);
      v[10] = -32'sd67;
      push_vertex(v, 1'b0);
      push_vertex(uniform_vertex(32'hffff_ffff), 1'b0);
      v = uniform_vertex(32'h7fff_ffff);
      v[9] = 32'h8000_0000;
      push_vertex(v, 1'b0);
      // new group empties the table before the lookup
      push_vertex(uniform_vertex(32'h7fff_ffff), 1'b1);
      push_vertex(uniform_vertex(32'd0), 1'b0);
      push_vertex(uniform_vertex(32'h7fff_ffff), 1'b0);

      // zero tolerance: exact matches only
      set_tolerance(16'd0);
      push_vertex(uniform_vertex(32'd5), 1'b1);
      push_vertex(uniform_vertex(32'd5), 1'b0);
      v = uniform_vertex(32'd5);
      v[3] = 32'd6;
      push_vertex(v, 1'b0);
      push_vertex(uniform_vertex(32'd4), 1'b0);

      // widest tolerance
      set_tolerance(16'hffff);
      push_vertex(uniform_vertex(32'h8000_0000), 1'b1);
      push_vertex(uniform_vertex(32'h8000_0000 + 32'd65535), 1'b0);
      push_vertex(uniform_vertex(32'h8000_0000 + 32'd65536), 1'b0);
      push_vertex(uniform_vertex(32'h7fff_ffff), 1'b0);
      push_vertex(uniform_vertex(32'h7fff_ffff - 32'd65535), 1'b0);

      // random phases over several tolerance settings
      run_random_phase(0, 105, 3, 45);
      run_random_phase(65535, 105, 3, 45);
      run_random_phase($urandom_range(1, 300), 105, 3, 45);
      run_random_phase(1, 105, 3, 45);

      // fill one group past the table depth, then keep looking up
      set_tolerance(TOL_W'($urandom_range(0, 65535)));
      group_vertices.delete();
      push_vertex(random_vertex(0, 100), 1'b1);
      for (int n = 0; n < 289; n++)
         push_vertex(random_vertex(int'(tolerance_now), 92), 1'b0);

      run_random_phase($urandom_range(0, 65535), 105, 4, 45);
      run_random_phase(66, 80, 3, 45);

      // drain, then let any stray result show up
      settle_idle();
      repeat (TABLE_DEPTH + 8) @(negedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog well beyond the slowest correct run
   initial begin
      #6_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> files.f
rtl/vdit_pkg.sv
rtl/vdit_cell.sv
rtl/vertex_dedup_index_table.sv
test/tb_vertex_dedup_index_table.sv
